[src/dtq_pkg.sv]
// Package for the deadline timer queue: sizes, action codes and shared types.
// No dependencies; used by every other file of the block but dtq_ram.
`timescale 1ns / 1ps

package dtq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned AddrW      = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned TagBits    = 16;
  localparam int unsigned TagW       = 16;
  localparam int unsigned DlW        = 32;

  localparam logic ActAdd  = 1'b0;
  localparam logic ActTick = 1'b1;

  typedef struct packed {
    logic [DlW-1:0]     deadline;
    logic [TagBits-1:0] tag;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic            fired;
    logic [TagW-1:0] fired_tag;
    logic [DlW-1:0]  fired_deadline;
    logic            became_earliest;
    logic            dropped_full;
    logic [CntW-1:0] occupancy;
  } res_t;

endpackage

[src/dtq_if.sv]
// Request and result channel interfaces of the deadline timer queue.
// Depends on dtq_pkg for field widths.
`timescale 1ns / 1ps

interface dtq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [dtq_pkg::DlW-1:0]    deadline;
  logic [dtq_pkg::TagW-1:0]   task_tag;
  logic [dtq_pkg::DlW-1:0]    now_time;

  modport source (output valid, action, deadline, task_tag, now_time, input ready);
  modport sink   (input valid, action, deadline, task_tag, now_time, output ready);
endinterface

interface dtq_res_if;
  logic                       valid;
  logic                       ready;
  logic                       fired;
  logic [dtq_pkg::TagW-1:0]   fired_tag;
  logic [dtq_pkg::DlW-1:0]    fired_deadline;
  logic                       became_earliest;
  logic                       dropped_full;
  logic [dtq_pkg::CntW-1:0]   occupancy;

  modport source (output valid, fired, fired_tag, fired_deadline, became_earliest,
                  dropped_full, occupancy, input ready);
  modport sink   (input valid, fired, fired_tag, fired_deadline, became_earliest,
                  dropped_full, occupancy, output ready);
endinterface

[src/deadline_timer_queue.sv]
// Deadline timer queue, the top level: sequencer, entry RAM and output register.
// Depends on dtq_pkg, dtq_if, dtq_ram, dtq_ctrl and dtq_out_reg.
`timescale 1ns / 1ps

// Holds up to 16 tasks (tag and deadline) kept sorted earliest first in one
// entry RAM, equal deadlines in arrival order. Every request gives exactly one
// result. An add into a full queue is dropped, and an add into an empty queue is
// written straight to slot 0; otherwise the tasks due later than the new one
// are shifted up one slot a cycle through the RAM port pair, from the tail.
// A tick that fires pops the head and shifts the rest down the same way.
// A result waits in the output register while the next request is taken.
// No clearing pass is needed after reset.

module deadline_timer_queue (
  input  logic     clk_i,
  input  logic     rst_ni,
  dtq_req_if.sink  req_i,
  dtq_res_if.source res_o
);

  logic                      res_valid;
  logic                      res_ready;
  dtq_pkg::res_t             res;
  logic                      ram_we;
  logic [dtq_pkg::AddrW-1:0] ram_waddr;
  logic [dtq_pkg::AddrW-1:0] ram_raddr;
  dtq_pkg::entry_t           ram_wdata;
  dtq_pkg::entry_t           ram_rdata;

  dtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  dtq_ram #(
    .Width (dtq_pkg::EntryW),
    .Depth (dtq_pkg::QueueDepth)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dtq_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_valid),
    .ready_o (res_ready),
    .res_i   (res),
    .res_o   (res_o)
  );

endmodule

[src/dtq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module dtq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/dtq_ctrl.sv]
// Sequencer of the deadline timer queue: keeps the slots sorted in the entry
// RAM by shifting on insert and pop, and holds head, count and result fields.
// Depends on dtq_pkg and dtq_req_if.
`timescale 1ns / 1ps

module dtq_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dtq_req_if.sink                     req_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output dtq_pkg::res_t               res_o,
  output logic                        ram_we_o,
  output logic [dtq_pkg::AddrW-1:0]   ram_waddr_o,
  output dtq_pkg::entry_t             ram_wdata_o,
  output logic [dtq_pkg::AddrW-1:0]   ram_raddr_o,
  input  dtq_pkg::entry_t             ram_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_HEAD,
    S_POP,
    S_DONE
  } state_e;

  state_e                    state_q, state_d;
  logic [dtq_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [dtq_pkg::AddrW-1:0] idx_q, idx_d;
  dtq_pkg::entry_t           new_q, new_d;
  dtq_pkg::entry_t           head_q, head_d;
  dtq_pkg::entry_t           fired_entry_q, fired_entry_d;
  logic                      fired_q, fired_d;
  logic                      dropped_q, dropped_d;
  logic                      added_q, added_d;
  dtq_pkg::entry_t           req_entry;
  logic                      accept;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign req_entry   = '{deadline: req_i.deadline,
                         tag:      req_i.task_tag[dtq_pkg::TagBits-1:0]};

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    new_d         = new_q;
    head_d        = head_q;
    fired_entry_d = fired_entry_q;
    fired_d       = fired_q;
    dropped_d     = dropped_q;
    added_d       = added_q;
    ram_we_o      = 1'b0;
    ram_waddr_o   = idx_q;
    ram_wdata_o   = new_q;
    ram_raddr_o   = idx_q;
    res_valid_o   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          fired_d       = 1'b0;
          dropped_d     = 1'b0;
          added_d       = 1'b0;
          fired_entry_d = '0;
          new_d         = req_entry;
          if (req_i.action == dtq_pkg::ActAdd) begin
            if (cnt_q == dtq_pkg::CntW'(dtq_pkg::QueueDepth)) begin
              dropped_d = 1'b1;
              state_d   = S_DONE;
            end else if (cnt_q == '0) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = '0;
              ram_wdata_o = req_entry;
              head_d      = req_entry;
              cnt_d       = cnt_q + dtq_pkg::CntW'(1);
              added_d     = 1'b1;
              state_d     = S_DONE;
            end else begin
              added_d     = 1'b1;
              ram_raddr_o = dtq_pkg::AddrW'(cnt_q - dtq_pkg::CntW'(1));
              idx_d       = dtq_pkg::AddrW'(cnt_q - dtq_pkg::CntW'(1));
              state_d     = S_INS;
            end
          end else begin
            if ((cnt_q != '0) && (head_q.deadline <= req_i.now_time)) begin
              fired_d       = 1'b1;
              fired_entry_d = head_q;
              if (cnt_q == dtq_pkg::CntW'(1)) begin
                cnt_d   = '0;
                state_d = S_DONE;
              end else begin
                ram_raddr_o = dtq_pkg::AddrW'(1);
                idx_d       = dtq_pkg::AddrW'(1);
                state_d     = S_POP;
              end
            end else begin
              state_d = S_DONE;
            end
          end
        end
      end
      S_INS: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q + dtq_pkg::AddrW'(1);
        if (ram_rdata_i.deadline > new_q.deadline) begin
          ram_wdata_o = ram_rdata_i;
          if (idx_q == '0) begin
            state_d = S_INS_HEAD;
          end else begin
            ram_raddr_o = idx_q - dtq_pkg::AddrW'(1);
            idx_d       = idx_q - dtq_pkg::AddrW'(1);
          end
        end else begin
          ram_wdata_o = new_q;
          cnt_d       = cnt_q + dtq_pkg::CntW'(1);
          state_d     = S_DONE;
        end
      end
      S_INS_HEAD: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = '0;
        ram_wdata_o = new_q;
        head_d      = new_q;
        cnt_d       = cnt_q + dtq_pkg::CntW'(1);
        state_d     = S_DONE;
      end
      S_POP: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q - dtq_pkg::AddrW'(1);
        ram_wdata_o = ram_rdata_i;
        if (idx_q == dtq_pkg::AddrW'(1)) begin
          head_d = ram_rdata_i;
        end
        if (dtq_pkg::CntW'(idx_q) == cnt_q - dtq_pkg::CntW'(1)) begin
          cnt_d   = cnt_q - dtq_pkg::CntW'(1);
          state_d = S_DONE;
        end else begin
          ram_raddr_o = idx_q + dtq_pkg::AddrW'(1);
          idx_d       = idx_q + dtq_pkg::AddrW'(1);
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.fired           = fired_q;
    res_o.fired_tag       = dtq_pkg::TagW'(fired_entry_q.tag);
    res_o.fired_deadline  = fired_entry_q.deadline;
    res_o.became_earliest = added_q && (head_q.deadline == new_q.deadline);
    res_o.dropped_full    = dropped_q;
    res_o.occupancy       = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    new_q         <= new_d;
    head_q        <= head_d;
    fired_entry_q <= fired_entry_d;
    fired_q       <= fired_d;
    dropped_q     <= dropped_d;
    added_q       <= added_d;
  end

  // count never exceeds the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= dtq_pkg::CntW'(dtq_pkg::QueueDepth))
    else $error("entry count above queue depth");

  // an insert scan only runs on a queue that is neither empty nor full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |->
      ((cnt_q != '0) && (cnt_q < dtq_pkg::CntW'(dtq_pkg::QueueDepth))))
    else $error("insert scan on empty or full queue");

  // a pop shift never reads slot zero and stays below the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> ((idx_q != '0) && (dtq_pkg::CntW'(idx_q) < cnt_q)))
    else $error("pop shift index out of range");

  // no ram write while a result is presented
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> !ram_we_o)
    else $error("ram write during result phase");

  // a taken result returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after result");

endmodule

[src/dtq_out_reg.sv]
// Output register of the deadline timer queue: holds one result until taken.
// Depends on dtq_pkg and dtq_res_if.
`timescale 1ns / 1ps

module dtq_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  dtq_pkg::res_t  res_i,
  dtq_res_if.source      res_o
);

  logic          valid_q, valid_d;
  dtq_pkg::res_t data_q;

  assign ready_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid           = valid_q;
  assign res_o.fired           = data_q.fired;
  assign res_o.fired_tag       = data_q.fired_tag;
  assign res_o.fired_deadline  = data_q.fired_deadline;
  assign res_o.became_earliest = data_q.became_earliest;
  assign res_o.dropped_full    = data_q.dropped_full;
  assign res_o.occupancy       = data_q.occupancy;

endmodule
